// ===== rtl/lisl_pkg.sv =====
// Shared constants and controller/datapath handshake types for the LIS length block.
package lisl_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_VALUE_WIDTH = 16;
   localparam int LEN_W               = 11;

   typedef struct packed {
      logic accept;
      logic start;
      logic step;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic probe_open;
      logic last;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/lisl_req_if.sv =====
// Input item channel: one sequence element and its last marker.
interface lisl_req_if #(
   parameter int VALUE_WIDTH = lisl_pkg::DEFAULT_VALUE_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic                          last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

// ===== rtl/lisl_rsp_if.sv =====
// Result item channel: subsequence length and overflow flag.
interface lisl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lisl_pkg::LEN_W-1:0]     seq_length;
   logic                           overflow;

   modport source (output valid, output seq_length, output overflow, input ready);
   modport sink (input valid, input seq_length, input overflow, output ready);
endinterface

// ===== rtl/lisl_ctrl.sv =====
// Controller state machine sequencing accept, binary search, table write and result.
module lisl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lisl_pkg::status_type status,
   output lisl_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_PROBE  = 5'b00100,
      S_UPDATE = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = status.probe_open ? S_PROBE : S_UPDATE;
         end
         S_PROBE: begin
            cmd.step = 1'b1;
            state_in = status.probe_open ? S_PROBE : S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_START))
      else $error("Accepted item did not start a search.");

   a_plain_item_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && !status.last) |=> (state_ff == S_IDLE))
      else $error("Item without last marker did not return to idle.");
`endif

endmodule

// ===== rtl/lisl_datapath.sv =====
// Datapath: tail table memory, binary search bounds, count, overflow and result register.
module lisl_datapath #(
   parameter int TABLE_DEPTH = lisl_pkg::DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = lisl_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lisl_pkg::cmd_type             cmd,
   output lisl_pkg::status_type          status,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lisl_pkg::LEN_W-1:0]    rsp_seq_length,
   output logic                          rsp_overflow
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int LEN_W  = lisl_pkg::LEN_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [VALUE_WIDTH-1:0] SIGN_C = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic                   last_ff;
   logic [CNT_W-1:0]       lo_ff, hi_ff, mid_ff;
   logic                   eq_ff;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]       len_ff;
   logic                   rsp_ovf_ff;

   logic                   gt;
   logic                   eqv;
   logic [CNT_W-1:0]       nlo, nhi, nmid;
   logic                   do_write;
   logic [CNT_W+LEN_W-1:0] used_ext;

   assign gt  = rd_data_ff > key_ff;
   assign eqv = rd_data_ff == key_ff;

   always_comb begin
      nlo = lo_ff;
      nhi = hi_ff;
      if (cmd.step) begin
         if (gt) begin
            nhi = mid_ff;
         end else begin
            nlo = mid_ff + CNT_W'(1);
         end
      end
   end

   assign nmid     = nlo + ((nhi - nlo) >> 1);
   assign do_write = cmd.update && !eq_ff && ((lo_ff < used_ff) || (used_ff < DEPTH_C));
   assign used_ext = {{LEN_W{1'b0}}, used_ff};

   assign status.probe_open = nlo < nhi;
   assign status.last       = last_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if ((cmd.start || cmd.step) && status.probe_open) begin
         rd_data_ff <= mem[nmid[ADDR_W-1:0]];
      end
      if (do_write) begin
         mem[lo_ff[ADDR_W-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff  <= VALUE_WIDTH'(req_value) ^ SIGN_C;
         last_ff <= req_last;
         lo_ff   <= '0;
         hi_ff   <= used_ff;
         eq_ff   <= 1'b0;
      end
      if (cmd.start || cmd.step) begin
         lo_ff  <= nlo;
         hi_ff  <= nhi;
         mid_ff <= nmid;
      end
      if (cmd.step && !gt) begin
         eq_ff <= eqv;
      end
      if (cmd.emit) begin
         len_ff     <= used_ext[LEN_W-1:0];
         rsp_ovf_ff <= ovf_ff;
      end
   end

   always_comb begin
      used_in      = used_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update && !eq_ff && !(lo_ff < used_ff)) begin
         if (used_ff < DEPTH_C) begin
            used_in = used_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         used_in      = '0;
         ovf_in       = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_seq_length = len_ff;
   assign rsp_overflow   = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DEPTH_C)
      else $error("Used count exceeds table depth.");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      (cmd.start || cmd.step) |-> (lo_ff <= hi_ff))
      else $error("Search bounds crossed.");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && !cmd.emit) |=> ovf_ff)
      else $error("Overflow flag dropped before the result was sent.");

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result register overwritten while still pending.");
`endif

endmodule

// ===== rtl/longest_increasing_subsequence_length.sv =====
// Top level of the streaming longest strictly increasing subsequence length block.
//
//   Channel   Direction   Payload                    Item meaning
//   req_if    in          value, last                one sequence element
//   rsp_if    out         seq_length, overflow       result after a last element
//
// For each element the controller passes through its start state, any probe states and its
// update state before the next accept; the binary search does one table read per cycle
// through the registered read port of the tail memory. A last element also passes through
// the result state, which loads the result register.
// Synchronous reset empties the table by clearing the count; no clearing pass is needed.
// A pending result waits in its own register while the next element is taken; the next
// last element then stalls in the result state until the receiver has taken it.
module longest_increasing_subsequence_length #(
   parameter int TABLE_DEPTH = lisl_pkg::DEFAULT_TABLE_DEPTH,
   parameter int VALUE_WIDTH = lisl_pkg::DEFAULT_VALUE_WIDTH
) (
   input logic                clock,
   input logic                reset,
   lisl_req_if.sink           req_if,
   lisl_rsp_if.source         rsp_if
);

   lisl_pkg::cmd_type    cmd;
   lisl_pkg::status_type status;
   logic                 ready;

   lisl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   lisl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_if.value),
      .req_last       (req_if.last),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_seq_length (rsp_if.seq_length),
      .rsp_overflow   (rsp_if.overflow)
   );

   assign req_if.ready = ready;

endmodule
